// ===== hw/rtl/gspl_pkg.sv =====
// Shared types and constants for the green-sorted palette lookup core.
package gspl_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int GREEN_LEVELS    = 256;
    localparam int SIZE_W          = 9;
    localparam int DIST_W          = 10;
    localparam logic [DIST_W-1:0] DIST_START = 10'd1000;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [7:0] original_slot;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] best_position;
    } result_t;

endpackage

// ===== hw/rtl/green_sorted_palette_lookup_core.sv =====
// Palette lookup core top level: config register, sequencer, memories and output register.
// Commands run one at a time. A load writes the palette memory directly, and a read takes its
// entry from the registered palette memory read. A build runs selection-sort passes, each of
// which reads every remaining entry through the single palette read port and swaps where
// needed, and fills the green start table one entry per cycle. A lookup walks outward from
// its start entry, and each entry probed on that walk is a read, then a compare.
// The result register lets a new command start while the previous result waits.
module green_sorted_palette_lookup_core #(
    parameter int MAX_ENTRIES = gspl_pkg::MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,   // palette_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // entry_slot, blue, green, red
    input  logic [1:0]  s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // best_position, entry_blue, entry_green, entry_red,
                                     // original_slot
    output logic [0:0]  m_tuser      // command_done
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [gspl_pkg::SIZE_W-1:0] size_reg;
    logic [gspl_pkg::SIZE_W-1:0] size_clamp;
    logic [CW-1:0]               n;

    logic                 res_valid, res_ready;
    gspl_pkg::result_t    res;
    gspl_pkg::result_t    m_data_reg;
    logic                 m_valid_reg;

    logic                 pal_we;
    logic [AW-1:0]        pal_waddr, pal_raddr;
    logic [31:0]          pal_wdata, pal_rdata;
    logic                 tbl_we;
    logic [7:0]           tbl_waddr, tbl_raddr, tbl_wdata, tbl_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= gspl_pkg::SIZE_W'(256);
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    always_comb begin
        size_clamp = size_reg;
        if (size_reg == '0) begin
            size_clamp = gspl_pkg::SIZE_W'(1);
        end else if (size_reg > gspl_pkg::SIZE_W'(MAX_ENTRIES)) begin
            size_clamp = gspl_pkg::SIZE_W'(MAX_ENTRIES);
        end
    end
    assign n = CW'(size_clamp);

    gspl_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .n         (n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_cmd     (gspl_pkg::cmd_t'(s_tuser)),
        .s_slot    (s_tdata[7:0]),
        .s_blue    (s_tdata[15:8]),
        .s_green   (s_tdata[23:16]),
        .s_red     (s_tdata[31:24]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .pal_we    (pal_we),
        .pal_waddr (pal_waddr),
        .pal_wdata (pal_wdata),
        .pal_raddr (pal_raddr),
        .pal_rdata (pal_rdata),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata)
    );

    gspl_ram #(.DW(32), .DEPTH(MAX_ENTRIES)) u_pal_mem (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    gspl_ram #(.DW(8), .DEPTH(gspl_pkg::GREEN_LEVELS)) u_tbl_mem (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // hold the result until the downstream side takes the transaction
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = 1'b1;

endmodule

// ===== hw/rtl/gspl_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module gspl_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/gspl_ctrl.sv =====
// Command sequencer: load, selection-sort build, outward lookup search and read.
module gspl_ctrl #(
    parameter int MAX_ENTRIES = gspl_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES),
    parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CW-1:0]        n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gspl_pkg::cmd_t       s_cmd,
    input  logic [7:0]           s_slot,
    input  logic [7:0]           s_blue,
    input  logic [7:0]           s_green,
    input  logic [7:0]           s_red,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gspl_pkg::result_t    res,
    output logic                 pal_we,
    output logic [AW-1:0]        pal_waddr,
    output logic [31:0]          pal_wdata,
    output logic [AW-1:0]        pal_raddr,
    input  logic [31:0]          pal_rdata,
    output logic                 tbl_we,
    output logic [7:0]           tbl_waddr,
    output logic [7:0]           tbl_wdata,
    output logic [7:0]           tbl_raddr,
    input  logic [7:0]           tbl_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_RESP, R_DATA,
        B_OUTER, B_SCAN, B_SWAPA, B_SWAPB, B_TCHK, B_TMID, B_TFILL, B_FMID, B_FFILL,
        L_START, L_PICK, L_EVAL
    } state_t;

    localparam int DW = gspl_pkg::DIST_W;

    state_t                 state_reg;
    logic [CW-1:0]          i_reg, scan_reg, up_reg, dnp_reg;
    logic [AW-1:0]          minpos_reg, runstart_reg, best_reg;
    logic [7:0]             minval_reg, prevg_reg;
    logic [31:0]            minword_reg, wordi_reg;
    logic [8:0]             fk_reg;
    logic                   turn_dn_reg, probe_dn_reg, rd_ok_reg;
    logic [DW-1:0]          bestd_reg;
    logic [7:0]             pb_reg, pg_reg, pr_reg;
    gspl_pkg::result_t      res_reg;

    logic [CW-1:0]          n_m1;
    logic [AW-1:0]          last_pos;
    logic                   up_ok, dn_ok, pick_up;
    logic [AW-1:0]          probe_pos;
    logic [AW:0]            mid_sum;
    logic [7:0]             gw;
    logic signed [DW:0]     gdiff;
    logic [DW-1:0]          cand_dist;
    logic [CW-1:0]          start_up;

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        absd = (a > b) ? a - b : b - a;
    endfunction

    assign n_m1      = n - CW'(1);
    assign last_pos  = n_m1[AW-1:0];
    assign up_ok     = up_reg < n;
    assign dn_ok     = dnp_reg != '0;
    assign pick_up   = up_ok && (!turn_dn_reg || !dn_ok);
    assign probe_pos = probe_dn_reg ? AW'(dnp_reg - CW'(1)) : up_reg[AW-1:0];
    assign gw        = pal_rdata[15:8];
    assign gdiff     = probe_dn_reg
                     ? $signed({3'b0, pg_reg}) - $signed({3'b0, gw})
                     : $signed({3'b0, gw}) - $signed({3'b0, pg_reg});
    assign cand_dist = DW'(absd(gw, pg_reg)) + DW'(absd(pal_rdata[7:0], pb_reg))
                     + DW'(absd(pal_rdata[23:16], pr_reg));
    assign start_up  = ({1'b0, tbl_rdata} > 9'(n)) ? n : CW'(tbl_rdata);

    always_comb begin
        mid_sum = {1'b0, runstart_reg} + {1'b0, i_reg[AW-1:0]};
        if (state_reg == B_FMID) begin
            mid_sum = {1'b0, runstart_reg} + {1'b0, last_pos};
        end
    end

    assign s_ready   = state_reg == S_IDLE;
    assign res_valid = state_reg == S_RESP;
    assign res       = res_reg;

    // memory port drive
    always_comb begin
        pal_we    = 1'b0;
        pal_waddr = s_slot[AW-1:0];
        pal_wdata = {s_slot, s_red, s_green, s_blue};
        pal_raddr = s_slot[AW-1:0];
        tbl_we    = 1'b0;
        tbl_waddr = fk_reg[7:0];
        tbl_wdata = 8'(i_reg[AW-1:0]);
        tbl_raddr = s_green;
        case (state_reg)
            S_IDLE: begin
                pal_we = s_valid && (s_cmd == gspl_pkg::CMD_LOAD)
                         && ({1'b0, s_slot} < 9'(MAX_ENTRIES));
            end
            B_OUTER: pal_raddr = i_reg[AW-1:0];
            B_SCAN:  pal_raddr = AW'(scan_reg + CW'(1));
            B_SWAPA: begin
                pal_we    = minpos_reg != i_reg[AW-1:0];
                pal_waddr = i_reg[AW-1:0];
                pal_wdata = minword_reg;
            end
            B_SWAPB: begin
                pal_we    = 1'b1;
                pal_waddr = minpos_reg;
                pal_wdata = wordi_reg;
            end
            B_TMID, B_FMID: begin
                tbl_we    = 1'b1;
                tbl_waddr = prevg_reg;
                tbl_wdata = 8'(mid_sum[AW:1]);
            end
            B_TFILL: tbl_we = fk_reg < {1'b0, minval_reg};
            B_FFILL: begin
                tbl_we    = fk_reg < 9'(gspl_pkg::GREEN_LEVELS);
                tbl_wdata = 8'(last_pos);
            end
            L_PICK: pal_raddr = pick_up ? up_reg[AW-1:0] : AW'(dnp_reg - CW'(1));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        res_reg   <= '0;
                        pb_reg    <= s_blue;
                        pg_reg    <= s_green;
                        pr_reg    <= s_red;
                        rd_ok_reg <= {1'b0, s_slot} < 9'(n);
                        case (s_cmd)
                            gspl_pkg::CMD_LOAD:   state_reg <= S_RESP;
                            gspl_pkg::CMD_BUILD: begin
                                i_reg        <= '0;
                                prevg_reg    <= '0;
                                runstart_reg <= '0;
                                state_reg    <= B_OUTER;
                            end
                            gspl_pkg::CMD_LOOKUP: state_reg <= L_START;
                            default:              state_reg <= R_DATA;
                        endcase
                    end
                end
                S_RESP: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                R_DATA: begin
                    if (rd_ok_reg) begin
                        res_reg.entry_blue    <= pal_rdata[7:0];
                        res_reg.entry_green   <= pal_rdata[15:8];
                        res_reg.entry_red     <= pal_rdata[23:16];
                        res_reg.original_slot <= pal_rdata[31:24];
                    end
                    state_reg <= S_RESP;
                end
                B_OUTER: begin
                    scan_reg  <= i_reg;
                    state_reg <= (i_reg == n) ? B_FMID : B_SCAN;
                end
                B_SCAN: begin
                    if (scan_reg == i_reg) begin
                        minpos_reg  <= scan_reg[AW-1:0];
                        minval_reg  <= gw;
                        minword_reg <= pal_rdata;
                        wordi_reg   <= pal_rdata;
                    end else if (gw < minval_reg) begin
                        minpos_reg  <= scan_reg[AW-1:0];
                        minval_reg  <= gw;
                        minword_reg <= pal_rdata;
                    end
                    scan_reg <= scan_reg + CW'(1);
                    if (scan_reg == n_m1) begin
                        state_reg <= B_SWAPA;
                    end
                end
                B_SWAPA: state_reg <= (minpos_reg != i_reg[AW-1:0]) ? B_SWAPB : B_TCHK;
                B_SWAPB: state_reg <= B_TCHK;
                B_TCHK: begin
                    if (minval_reg != prevg_reg) begin
                        state_reg <= B_TMID;
                    end else begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= B_OUTER;
                    end
                end
                B_TMID: begin
                    fk_reg       <= {1'b0, prevg_reg} + 9'd1;
                    prevg_reg    <= minval_reg;
                    runstart_reg <= i_reg[AW-1:0];
                    state_reg    <= B_TFILL;
                end
                B_TFILL: begin
                    fk_reg <= fk_reg + 9'd1;
                    if (fk_reg >= {1'b0, minval_reg}) begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= B_OUTER;
                    end
                end
                B_FMID: begin
                    fk_reg    <= {1'b0, prevg_reg} + 9'd1;
                    state_reg <= B_FFILL;
                end
                B_FFILL: begin
                    fk_reg <= fk_reg + 9'd1;
                    if (fk_reg >= 9'(gspl_pkg::GREEN_LEVELS)) begin
                        state_reg <= S_RESP;
                    end
                end
                L_START: begin
                    up_reg      <= start_up;
                    dnp_reg     <= start_up;
                    turn_dn_reg <= 1'b0;
                    bestd_reg   <= gspl_pkg::DIST_START;
                    best_reg    <= '0;
                    state_reg   <= L_PICK;
                end
                L_PICK: begin
                    probe_dn_reg <= !pick_up;
                    if (!up_ok && !dn_ok) begin
                        res_reg.best_position <= 8'(best_reg);
                        state_reg             <= S_RESP;
                    end else begin
                        state_reg <= L_EVAL;
                    end
                end
                L_EVAL: begin
                    turn_dn_reg <= !probe_dn_reg;
                    if (gdiff >= $signed({1'b0, bestd_reg})) begin
                        // green gap alone reaches or exceeds best: drop this direction
                        if (probe_dn_reg) begin
                            dnp_reg <= '0;
                        end else begin
                            up_reg <= n;
                        end
                    end else begin
                        if (cand_dist < bestd_reg) begin
                            bestd_reg <= cand_dist;
                            best_reg  <= probe_pos;
                        end
                        if (probe_dn_reg) begin
                            dnp_reg <= dnp_reg - CW'(1);
                        end else begin
                            up_reg <= up_reg + CW'(1);
                        end
                    end
                    state_reg <= L_PICK;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_best_dist_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == L_EVAL) |=> (bestd_reg <= $past(bestd_reg)))
        else $error("best distance grew during lookup");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SCAN) |-> (scan_reg < n))
        else $error("sort scan beyond palette size");

    a_swap_needs_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SWAPB) |-> (minpos_reg != i_reg[AW-1:0]))
        else $error("swap write with no moved entry");

endmodule
